>>> design/nsfc_pkg.sv
// Shared types and constants for the NMEA sentence framer and checker.
// No dependencies; imported by every module of the block.
package nsfc_pkg;

    localparam int MAX_SENTENCE = 128;
    localparam int LEN_W        = $clog2(MAX_SENTENCE);
    localparam int RES_W        = 156;
    localparam int TDATA_W      = 160;

    localparam logic [LEN_W-1:0] OVERRUN_LEN = LEN_W'(MAX_SENTENCE - 1);
    localparam logic [4:0]       FIELD_CAP   = 5'd24;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_NUL    = 8'h00;

    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_ACCEPT  = 3'd1,
        EV_BADSUM  = 3'd2,
        EV_UNKNOWN = 3'd3,
        EV_OVERRUN = 3'd4
    } event_t;

    typedef enum logic [2:0] {
        KIND_UNKNOWN = 3'd0,
        KIND_GGA     = 3'd1,
        KIND_RMC     = 3'd2,
        KIND_GSA     = 3'd3,
        KIND_GSV     = 3'd4
    } kind_t;

    // First declared member sits in the top bits
    typedef struct packed {
        logic [31:0] overrun_total;
        logic [31:0] checksum_fail_total;
        logic [31:0] unrecognised_total;
        logic [31:0] accepted_total;
        logic [4:0]  fields_seen;
        logic [7:0]  talker_second;
        logic [7:0]  talker_first;
        kind_t       sentence_kind;
        logic        accepted;
        event_t      event_code;
    } res_t;

endpackage

>>> design/nmea_sentence_framer_checker.sv
// NMEA sentence framer and checker: input register, per-byte engine, result register.
// An accepted byte waits in the input register until the result register can load.
// Throughput: one byte per cycle; s_tready follows m_tready through the result register.
// Every byte gives exactly one result transaction, carrying event, head and counters.
// Reset: synchronous, active low; clears sentence state, counters and both valid flags.
// Depends on nsfc_pkg, nsfc_engine and nsfc_out_reg.
module nmea_sentence_framer_checker
    import nsfc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // [7:0] byte_in
    output logic               m_tvalid,
    input  logic               m_tready,
    // [2:0] event_code, [3] accepted, [6:4] sentence_kind, [14:7] talker_first,
    // [22:15] talker_second, [27:23] fields_seen, [59:28] accepted_total,
    // [91:60] unrecognised_total, [123:92] checksum_fail_total,
    // [155:124] overrun_total, [159:156] zero
    output logic [TDATA_W-1:0] m_tdata
);

    logic       in_vld_reg, in_vld_next;
    logic [7:0] in_byte_reg;
    logic       out_load;
    logic       s_accept;
    res_t       result;

    assign out_load = in_vld_reg && (!m_tvalid || m_tready);
    assign s_tready = !in_vld_reg || out_load;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        in_vld_next = in_vld_reg;
        if (s_accept) begin
            in_vld_next = 1'b1;
        end else if (out_load) begin
            in_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else begin
            in_vld_reg <= in_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_byte_reg <= s_tdata;
        end
    end

    nsfc_engine u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (out_load),
        .byte_in (in_byte_reg),
        .result  (result)
    );

    nsfc_out_reg u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (out_load),
        .result   (result),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

>>> design/nsfc_engine.sv
// Sentence state, checksum and field tracking, and outcome counters.
// Depends on nsfc_pkg; produces one result per processed byte.
module nsfc_engine
    import nsfc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step,
    input  logic [7:0] byte_in,
    output res_t       result
);

    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic [7:0]       xor_acc;
        logic             star;
        logic [1:0]       hex_cnt;
        logic [7:0]       rx_sum;
        logic             bad_hex;
        logic             text_end;
        logic [4:0]       fields;
        logic [39:0]      head;
        logic [2:0]       head_len;
    } sent_t;

    localparam sent_t SENT_CLEAR = '{
        len: '0, xor_acc: 8'h00, star: 1'b0, hex_cnt: 2'd0, rx_sum: 8'h00,
        bad_hex: 1'b0, text_end: 1'b0, fields: 5'd1, head: 40'h0, head_len: 3'd0
    };

    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        v = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = {1'b1, 4'(c - 8'h37)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = {1'b1, 4'(c - 8'h57)};
        end
        return v;
    endfunction

    function automatic kind_t head_kind(input logic [39:0] h, input logic [2:0] hl);
        kind_t k;
        k = KIND_UNKNOWN;
        if (hl == 3'd5) begin
            if (h[23:16] == "G" && h[31:24] == "G" && h[39:32] == "A") begin
                k = KIND_GGA;
            end else if (h[23:16] == "R" && h[31:24] == "M" && h[39:32] == "C") begin
                k = KIND_RMC;
            end else if (h[23:16] == "G" && h[31:24] == "S" && h[39:32] == "A") begin
                k = KIND_GSA;
            end else if (h[23:16] == "G" && h[31:24] == "S" && h[39:32] == "V") begin
                k = KIND_GSV;
            end
        end
        return k;
    endfunction

    function automatic logic [4:0] need_fields(input kind_t k);
        logic [4:0] n;
        case (k)
            KIND_GGA: n = 5'd10;
            KIND_RMC: n = 5'd10;
            KIND_GSA: n = 5'd18;
            KIND_GSV: n = 5'd4;
            default:  n = 5'd0;
        endcase
        return n;
    endfunction

    sent_t       st_reg, st_next;
    logic        in_sent_reg, in_sent_next;
    logic [31:0] good_reg, good_next;
    logic [31:0] unk_reg, unk_next;
    logic [31:0] bad_reg, bad_next;
    logic [31:0] ovr_reg, ovr_next;

    logic [4:0]  hv;
    logic        sum_ok;
    kind_t       kind;

    assign hv     = hex_value(byte_in);
    assign sum_ok = st_reg.star && (st_reg.hex_cnt == 2'd2) && !st_reg.bad_hex &&
                    (st_reg.xor_acc == st_reg.rx_sum);
    assign kind   = head_kind(st_reg.head, st_reg.head_len);

    always_comb begin
        st_next      = st_reg;
        in_sent_next = in_sent_reg;
        good_next    = good_reg;
        unk_next     = unk_reg;
        bad_next     = bad_reg;
        ovr_next     = ovr_reg;
        result       = '0;

        if (byte_in == CH_DOLLAR) begin
            in_sent_next = 1'b1;
            st_next      = SENT_CLEAR;
        end else if (in_sent_reg) begin
            if (byte_in == CH_CR || byte_in == CH_LF) begin
                in_sent_next = 1'b0;
                st_next      = SENT_CLEAR;
                if (st_reg.len != '0) begin
                    if (!sum_ok) begin
                        bad_next          = bad_reg + 32'd1;
                        result.event_code = EV_BADSUM;
                    end else begin
                        result.sentence_kind = kind;
                        result.talker_first  = st_reg.head[7:0];
                        result.talker_second = st_reg.head[15:8];
                        result.fields_seen   = st_reg.fields;
                        if (kind != KIND_UNKNOWN && st_reg.fields >= need_fields(kind)) begin
                            good_next         = good_reg + 32'd1;
                            result.event_code = EV_ACCEPT;
                            result.accepted   = 1'b1;
                        end else begin
                            unk_next          = unk_reg + 32'd1;
                            result.event_code = EV_UNKNOWN;
                        end
                    end
                end
            end else if (st_reg.len >= OVERRUN_LEN) begin
                // drop the sentence: the body would reach the length limit
                ovr_next          = ovr_reg + 32'd1;
                in_sent_next      = 1'b0;
                st_next           = SENT_CLEAR;
                result.event_code = EV_OVERRUN;
            end else begin
                st_next.len = st_reg.len + 1'b1;
                if (!st_reg.text_end) begin
                    if (byte_in == CH_NUL) begin
                        st_next.text_end = 1'b1;
                    end else if (!st_reg.star) begin
                        if (byte_in == CH_STAR) begin
                            st_next.star = 1'b1;
                        end else begin
                            if (!(st_reg.len == '0 && byte_in == CH_BANG)) begin
                                st_next.xor_acc = st_reg.xor_acc ^ byte_in;
                            end
                            if (byte_in == CH_COMMA) begin
                                if (st_reg.fields < FIELD_CAP) begin
                                    st_next.fields = st_reg.fields + 5'd1;
                                end
                            end else if (st_reg.fields == 5'd1 && st_reg.head_len < 3'd6) begin
                                case (st_reg.head_len)
                                    3'd0:    st_next.head[7:0]   = byte_in;
                                    3'd1:    st_next.head[15:8]  = byte_in;
                                    3'd2:    st_next.head[23:16] = byte_in;
                                    3'd3:    st_next.head[31:24] = byte_in;
                                    3'd4:    st_next.head[39:32] = byte_in;
                                    default: st_next.head        = st_reg.head;
                                endcase
                                st_next.head_len = st_reg.head_len + 3'd1;
                            end
                        end
                    end else if (st_reg.hex_cnt < 2'd2) begin
                        if (!hv[4]) begin
                            st_next.bad_hex = 1'b1;
                        end else begin
                            st_next.rx_sum = {st_reg.rx_sum[3:0], hv[3:0]};
                        end
                        st_next.hex_cnt = st_reg.hex_cnt + 2'd1;
                    end
                end
            end
        end

        result.accepted_total      = good_next;
        result.unrecognised_total  = unk_next;
        result.checksum_fail_total = bad_next;
        result.overrun_total       = ovr_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg      <= SENT_CLEAR;
            in_sent_reg <= 1'b0;
            good_reg    <= 32'd0;
            unk_reg     <= 32'd0;
            bad_reg     <= 32'd0;
            ovr_reg     <= 32'd0;
        end else if (step) begin
            st_reg      <= st_next;
            in_sent_reg <= in_sent_next;
            good_reg    <= good_next;
            unk_reg     <= unk_next;
            bad_reg     <= bad_next;
            ovr_reg     <= ovr_next;
        end
    end

endmodule

>>> design/nsfc_out_reg.sv
// Result register for the master stream side.
// Depends on nsfc_pkg for the result layout.
module nsfc_out_reg
    import nsfc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               load,
    input  res_t               result,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata
);

    logic vld_reg, vld_next;
    res_t res_reg;

    always_comb begin
        vld_next = vld_reg;
        if (load) begin
            vld_next = 1'b1;
        end else if (m_tready) begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    // payload holds while the transaction is stalled
    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= result;
        end
    end

    assign m_tvalid = vld_reg;
    assign m_tdata  = {(TDATA_W - RES_W)'(0), res_reg};

endmodule

>>> design/nsfc_checker.sv
// Port-level checks for the NMEA sentence framer and checker, and the bind to it.
// Depends on nsfc_pkg for the result layout and event codes.
module nsfc_checker
    import nsfc_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_tvalid,
    input logic               s_tready,
    input logic [7:0]         s_tdata,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [TDATA_W-1:0] m_tdata
);

    res_t r;
    assign r = m_tdata[RES_W-1:0];

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result transaction changed while stalled");

    a_acc_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (r.accepted == (r.event_code == EV_ACCEPT)))
        else $error("accepted flag disagrees with event code");

    a_blank: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (r.event_code == EV_NONE || r.event_code == EV_BADSUM ||
                     r.event_code == EV_OVERRUN)
        |-> r.sentence_kind == KIND_UNKNOWN && r.talker_first == 8'h00 &&
            r.talker_second == 8'h00 && r.fields_seen == 5'd0)
        else $error("head fields not blank for this event");

    a_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && r.event_code == EV_ACCEPT
        |-> r.sentence_kind != KIND_UNKNOWN && r.fields_seen >= 5'd4)
        else $error("accepted sentence without kind or fields");

    a_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> r.fields_seen <= FIELD_CAP)
        else $error("field count above cap");

endmodule

bind nmea_sentence_framer_checker nsfc_checker u_nsfc_checker (.*);
